>>> design/limit_order_book_matcher_core_macros.svh
// assertion macros shared by the checker
`ifndef LIMIT_ORDER_BOOK_MATCHER_CORE_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define LOBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define LOBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lobm_pkg.sv
`timescale 1ns / 1ps

package lobm_pkg;

    localparam int unsigned PRICE_LEVELS_DEF = 1024;
    localparam int unsigned QTY_W            = 32;
    localparam int unsigned PRICE_W          = 32;
    localparam int unsigned REF_W            = 32;
    localparam int unsigned TRADE_PRICE_W    = 10;
    localparam logic [QTY_W-1:0] QTY_MAX     = '1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_OPP,
        ST_WAIT_OPP,
        ST_TRADE,
        ST_READ_OWN,
        ST_WAIT_OWN,
        ST_REST,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

>>> design/lobm_ram.sv
`timescale 1ns / 1ps

module lobm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/limit_order_book_matcher_core.sv
`timescale 1ns / 1ps
// channel | direction | handshake             | fields
// order   | in        | start & !busy         | order_valid, order_side, order_price,
//         |           |                       | order_quantity, order_reference
// result  | out       | result_valid (1 cycle)| matched, trade_price, trade_quantity,
//         |           |                       | taker_reference
// after reset the level stores are cleared, with busy high
// an in-range order keeps busy high from READ_OPP to DONE, via WAIT_OPP and TRADE when it trades
// an out-of-range order goes from IDLE straight to DONE; the result beat follows once busy drops
// emptying a best level adds a scan that primes a read, then walks on until a nonempty level or the end
// an invalid beat leaves busy low and yields no result; the receiver cannot stall

module limit_order_book_matcher_core #(
    parameter int unsigned PRICE_LEVELS = lobm_pkg::PRICE_LEVELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 order_valid,
    input  logic                                 order_side,
    input  logic [lobm_pkg::PRICE_W-1:0]         order_price,
    input  logic [lobm_pkg::QTY_W-1:0]           order_quantity,
    input  logic [lobm_pkg::REF_W-1:0]           order_reference,
    output logic                                 result_valid,
    output logic                                 matched,
    output logic [lobm_pkg::TRADE_PRICE_W-1:0]   trade_price,
    output logic [lobm_pkg::QTY_W-1:0]           trade_quantity,
    output logic [lobm_pkg::REF_W-1:0]           taker_reference
);

    localparam int unsigned AW = $clog2(PRICE_LEVELS);
    localparam logic [AW-1:0] TOP = AW'(PRICE_LEVELS - 1);
    localparam int unsigned QW = lobm_pkg::QTY_W;

    lobm_pkg::state_t state_reg, state_next;

    logic [AW-1:0]  addr_reg, addr_next;
    logic           side_reg, side_next;
    logic [AW-1:0]  price_reg, price_next;
    logic [QW-1:0]  qty_reg, qty_next;
    logic [AW-1:0]  bid_top_reg, bid_top_next;
    logic [AW-1:0]  ask_top_reg, ask_top_next;
    logic           hit_reg, hit_next;
    logic [AW-1:0]  lvl_reg, lvl_next;
    logic           rv_reg, rv_next;
    logic           m_reg, m_next;
    logic [lobm_pkg::TRADE_PRICE_W-1:0] tp_reg, tp_next;
    logic [QW-1:0]  tq_reg, tq_next;
    logic [lobm_pkg::REF_W-1:0] ref_reg, ref_next;
    logic           empty_reg, empty_next;
    logic           scan_started_reg, scan_started_next;

    logic          bid_we, ask_we;
    logic [AW-1:0] waddr, raddr;
    logic [QW-1:0] wdata, bid_rdata, ask_rdata, opp_q, own_q, traded;
    logic [QW:0]   sum;

    lobm_ram #(.WIDTH(QW), .DEPTH(PRICE_LEVELS)) u_bid_ram (
        .clk(clk), .we(bid_we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(bid_rdata)
    );

    lobm_ram #(.WIDTH(QW), .DEPTH(PRICE_LEVELS)) u_ask_ram (
        .clk(clk), .we(ask_we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(ask_rdata)
    );

    assign opp_q  = side_reg ? bid_rdata : ask_rdata;
    assign own_q  = side_reg ? ask_rdata : bid_rdata;
    assign traded = (qty_reg < opp_q) ? qty_reg : opp_q;
    assign sum    = {1'b0, own_q} + {1'b0, qty_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lobm_pkg::ST_CLEAR;
            addr_reg     <= '0;
            bid_top_reg  <= '0;
            ask_top_reg  <= '0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            bid_top_reg  <= bid_top_next;
            ask_top_reg  <= ask_top_next;
            rv_reg       <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg  <= side_next;
        price_reg <= price_next;
        qty_reg   <= qty_next;
        hit_reg   <= hit_next;
        lvl_reg   <= lvl_next;
        m_reg     <= m_next;
        tp_reg    <= tp_next;
        tq_reg    <= tq_next;
        ref_reg   <= ref_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lobm_pkg::ST_CLEAR:
            begin
                if (addr_reg == TOP)
                begin
                    state_next = lobm_pkg::ST_IDLE;
                end
            end
            lobm_pkg::ST_IDLE:
            begin
                if (start && order_valid)
                begin
                    state_next = (order_price >= lobm_pkg::PRICE_W'(PRICE_LEVELS))
                        ? lobm_pkg::ST_DONE : lobm_pkg::ST_READ_OPP;
                end
            end
            lobm_pkg::ST_READ_OPP:
            begin
                if (side_reg ? (bid_top_reg != '0 && price_reg <= bid_top_reg)
                             : (ask_top_reg != '0 && price_reg >= ask_top_reg))
                begin
                    state_next = lobm_pkg::ST_WAIT_OPP;
                end
                else
                begin
                    state_next = lobm_pkg::ST_READ_OWN;
                end
            end
            lobm_pkg::ST_WAIT_OPP: state_next = lobm_pkg::ST_TRADE;
            lobm_pkg::ST_TRADE:    state_next = lobm_pkg::ST_READ_OWN;
            lobm_pkg::ST_READ_OWN:
            begin
                if (hit_reg && qty_reg == '0)
                begin
                    state_next = (opp_empty_pending()) ? lobm_pkg::ST_SCAN
                                                       : lobm_pkg::ST_DONE;
                end
                else
                begin
                    state_next = lobm_pkg::ST_WAIT_OWN;
                end
            end
            lobm_pkg::ST_WAIT_OWN: state_next = lobm_pkg::ST_REST;
            lobm_pkg::ST_REST:
            begin
                state_next = opp_empty_pending() ? lobm_pkg::ST_SCAN : lobm_pkg::ST_DONE;
            end
            lobm_pkg::ST_SCAN:
            begin
                if (scan_stop())
                begin
                    state_next = lobm_pkg::ST_DONE;
                end
            end
            lobm_pkg::ST_DONE:     state_next = lobm_pkg::ST_IDLE;
            default:               state_next = lobm_pkg::ST_IDLE;
        endcase
    end

    // lvl_reg holds the emptied best while a scan is owed; m_reg with empty_reg marks it
    function automatic logic opp_empty_pending();
        opp_empty_pending = m_reg && empty_reg;
    endfunction

    always_ff @(posedge clk)
    begin
        empty_reg        <= empty_next;
        scan_started_reg <= scan_started_next;
    end

    // scan: addr_reg is the level whose data arrives this cycle (once primed)
    function automatic logic scan_stop();
        logic [QW-1:0] q;
        logic          last;
        q = side_reg ? bid_rdata : ask_rdata;
        last = side_reg ? (addr_reg == '0) : (addr_reg == TOP);
        if (!scan_started_reg)
        begin
            scan_stop = side_reg ? (lvl_reg == '0) : (lvl_reg == TOP);
        end
        else
        begin
            scan_stop = (q != '0) || last;
        end
    endfunction

    always_comb
    begin
        addr_next         = addr_reg;
        side_next         = side_reg;
        price_next        = price_reg;
        qty_next          = qty_reg;
        hit_next          = hit_reg;
        lvl_next          = lvl_reg;
        m_next            = m_reg;
        tp_next           = tp_reg;
        tq_next           = tq_reg;
        ref_next          = ref_reg;
        empty_next        = empty_reg;
        scan_started_next = scan_started_reg;
        bid_top_next      = bid_top_reg;
        ask_top_next      = ask_top_reg;
        rv_next           = 1'b0;
        bid_we            = 1'b0;
        ask_we            = 1'b0;
        waddr             = addr_reg;
        wdata             = '0;
        raddr             = addr_reg;
        unique case (state_reg)
            lobm_pkg::ST_CLEAR:
            begin
                bid_we    = 1'b1;
                ask_we    = 1'b1;
                addr_next = addr_reg + AW'(1);
            end
            lobm_pkg::ST_IDLE:
            begin
                side_next  = order_side;
                price_next = order_price[AW-1:0];
                qty_next   = order_quantity;
                ref_next   = order_reference;
                hit_next   = 1'b0;
                m_next     = 1'b0;
                tp_next    = '0;
                tq_next    = '0;
                empty_next = 1'b0;
            end
            lobm_pkg::ST_READ_OPP:
            begin
                raddr    = side_reg ? bid_top_reg : ask_top_reg;
                lvl_next = raddr;
            end
            lobm_pkg::ST_WAIT_OPP:
            begin
                raddr = lvl_reg;
            end
            lobm_pkg::ST_TRADE:
            begin
                hit_next   = 1'b1;
                m_next     = 1'b1;
                tp_next    = lobm_pkg::TRADE_PRICE_W'(lvl_reg);
                tq_next    = traded;
                qty_next   = qty_reg - traded;
                empty_next = (opp_q - traded) == '0;
                waddr      = lvl_reg;
                wdata      = opp_q - traded;
                bid_we     = side_reg;
                ask_we     = !side_reg;
                // a zero trade of a nonzero level must not scan
                if (traded == '0)
                begin
                    empty_next = (opp_q == '0);
                end
            end
            lobm_pkg::ST_READ_OWN:
            begin
                raddr = price_reg;
            end
            lobm_pkg::ST_WAIT_OWN:
            begin
                raddr = price_reg;
            end
            lobm_pkg::ST_REST:
            begin
                waddr  = price_reg;
                wdata  = sum[QW] ? lobm_pkg::QTY_MAX : sum[QW-1:0];
                bid_we = !side_reg;
                ask_we = side_reg;
                if (side_reg)
                begin
                    if (price_reg < ask_top_reg || ask_top_reg == '0)
                    begin
                        ask_top_next = price_reg;
                    end
                end
                else
                begin
                    if (price_reg > bid_top_reg || bid_top_reg == '0)
                    begin
                        bid_top_next = price_reg;
                    end
                end
            end
            lobm_pkg::ST_SCAN:
            begin
                if (!scan_started_reg)
                begin
                    scan_started_next = 1'b1;
                    addr_next = side_reg ? lvl_reg - AW'(1) : lvl_reg + AW'(1);
                    raddr     = addr_next;
                    if (scan_stop())
                    begin
                        set_opp_best('0);
                    end
                end
                else
                begin
                    addr_next = side_reg ? addr_reg - AW'(1) : addr_reg + AW'(1);
                    raddr     = addr_next;
                    if ((side_reg ? bid_rdata : ask_rdata) != '0)
                    begin
                        set_opp_best(addr_reg);
                    end
                    else if (scan_stop())
                    begin
                        set_opp_best('0);
                    end
                end
            end
            lobm_pkg::ST_DONE:
            begin
                rv_next           = 1'b1;
                scan_started_next = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (state_reg != lobm_pkg::ST_SCAN)
        begin
            if (state_reg != lobm_pkg::ST_DONE)
            begin
                scan_started_next = (state_reg == lobm_pkg::ST_IDLE) ? 1'b0 : scan_started_reg;
            end
        end
    end

    // the best of the opposite side is the one the scan repairs
    task automatic set_opp_best(input logic [AW-1:0] v);
        if (side_reg)
        begin
            bid_top_next = v;
        end
        else
        begin
            ask_top_next = v;
        end
    endtask

    assign busy            = state_reg != lobm_pkg::ST_IDLE;
    assign result_valid    = rv_reg;
    assign matched         = m_reg;
    assign trade_price     = tp_reg;
    assign trade_quantity  = tq_reg;
    assign taker_reference = ref_reg;

endmodule

>>> design/limit_order_book_matcher_core_chk.sv
`timescale 1ns / 1ps
`include "limit_order_book_matcher_core_macros.svh"

module limit_order_book_matcher_core_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        order_valid,
    input logic        result_valid,
    input logic        matched,
    input logic [9:0]  trade_price,
    input logic [31:0] trade_quantity
);

    `LOBM_ASSERT_IMP(a_nomatch_zero, clk, rst_n, result_valid && !matched, trade_price == '0 && trade_quantity == '0, "unmatched result carries trade data")
    `LOBM_ASSERT_IMP(a_match_level, clk, rst_n, result_valid && matched, trade_price != '0, "trade at level zero")
    `LOBM_ASSERT_NEXT(a_strobe_single, clk, rst_n, result_valid, !result_valid, "result strobe longer than one cycle")
    `LOBM_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy && order_valid, busy, "accepted order did not raise busy")

endmodule

bind limit_order_book_matcher_core limit_order_book_matcher_core_chk u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .order_valid(order_valid),
    .result_valid(result_valid), .matched(matched), .trade_price(trade_price),
    .trade_quantity(trade_quantity)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned LEVELS = lobm_pkg::PRICE_LEVELS_DEF;
    localparam int unsigned LIMIT  = 10000000;

    typedef struct packed {
        logic                               matched;
        logic [lobm_pkg::TRADE_PRICE_W-1:0] price;
        logic [lobm_pkg::QTY_W-1:0]         quantity;
        logic [lobm_pkg::REF_W-1:0]         reference;
    } fill_t;

    class book_scoreboard;
        logic [lobm_pkg::QTY_W-1:0] bid_qty [LEVELS];
        logic [lobm_pkg::QTY_W-1:0] ask_qty [LEVELS];
        int unsigned      bid_top;
        int unsigned      ask_top;
        fill_t            pending [$];
        int unsigned      errors;

        function void clear();
            foreach (bid_qty[i])
            begin
                bid_qty[i] = '0;
                ask_qty[i] = '0;
            end
            bid_top = 0;
            ask_top = 0;
            errors = 0;
        endfunction

        function logic [lobm_pkg::QTY_W-1:0] sat_add(logic [lobm_pkg::QTY_W-1:0] a,
                                                     logic [lobm_pkg::QTY_W-1:0] b);
            logic [lobm_pkg::QTY_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[lobm_pkg::QTY_W] ? lobm_pkg::QTY_MAX : s[lobm_pkg::QTY_W-1:0];
        endfunction

        function void note_order(logic vld, logic side, logic [lobm_pkg::PRICE_W-1:0] price,
                                 logic [lobm_pkg::QTY_W-1:0] qty,
                                 logic [lobm_pkg::REF_W-1:0] ref_id);
            fill_t                      f;
            int unsigned                p;
            int unsigned                lvl;
            logic [lobm_pkg::QTY_W-1:0] avail;
            logic [lobm_pkg::QTY_W-1:0] traded;
            logic [lobm_pkg::QTY_W-1:0] rest;
            bit                         hit;
            if (!vld)
                return;
            f = '0;
            f.reference = ref_id;
            hit = 0;
            rest = qty;
            if (price < LEVELS)
            begin
                p = price;
                if (side == 1'b0)
                begin
                    if (ask_top != 0 && p >= ask_top)
                    begin
                        lvl = ask_top;
                        avail = ask_qty[lvl];
                        traded = (qty < avail) ? qty : avail;
                        hit = 1;
                        f.matched = 1'b1;
                        f.price = lvl[lobm_pkg::TRADE_PRICE_W-1:0];
                        f.quantity = traded;
                        ask_qty[lvl] = avail - traded;
                        if (ask_qty[lvl] == 0)
                        begin
                            ask_top = 0;
                            for (int i = lvl + 1; i < LEVELS; i++)
                                if (ask_qty[i] != 0)
                                begin
                                    ask_top = i;
                                    break;
                                end
                        end
                        rest = qty - traded;
                    end
                    if (!hit || rest != 0)
                    begin
                        bid_qty[p] = sat_add(bid_qty[p], rest);
                        if (p > bid_top || bid_top == 0)
                            bid_top = p;
                    end
                end
                else
                begin
                    if (bid_top != 0 && p <= bid_top)
                    begin
                        lvl = bid_top;
                        avail = bid_qty[lvl];
                        traded = (qty < avail) ? qty : avail;
                        hit = 1;
                        f.matched = 1'b1;
                        f.price = lvl[lobm_pkg::TRADE_PRICE_W-1:0];
                        f.quantity = traded;
                        bid_qty[lvl] = avail - traded;
                        if (bid_qty[lvl] == 0)
                        begin
                            bid_top = 0;
                            for (int i = int'(lvl) - 1; i >= 0; i--)
                                if (bid_qty[i] != 0)
                                begin
                                    bid_top = i;
                                    break;
                                end
                        end
                        rest = qty - traded;
                    end
                    if (!hit || rest != 0)
                    begin
                        ask_qty[p] = sat_add(ask_qty[p], rest);
                        if (p < ask_top || ask_top == 0)
                            ask_top = p;
                    end
                end
            end
            pending.push_back(f);
        endfunction

        function void check_fill(fill_t got);
            fill_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat ref=%h", got.reference);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.matched !== e.matched)
            begin
                $error("matched: expected %0d actual %0d", e.matched, got.matched);
                errors++;
            end
            if (got.price !== e.price)
            begin
                $error("trade_price: expected %0d actual %0d", e.price, got.price);
                errors++;
            end
            if (got.quantity !== e.quantity)
            begin
                $error("trade_quantity: expected %0d actual %0d", e.quantity, got.quantity);
                errors++;
            end
            if (got.reference !== e.reference)
            begin
                $error("taker_reference: expected %h actual %h", e.reference, got.reference);
                errors++;
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic                               order_valid;
    logic                               order_side;
    logic [lobm_pkg::PRICE_W-1:0]       order_price;
    logic [lobm_pkg::QTY_W-1:0]         order_quantity;
    logic [lobm_pkg::REF_W-1:0]         order_reference;
    logic                               result_valid;
    logic                               matched;
    logic [lobm_pkg::TRADE_PRICE_W-1:0] trade_price;
    logic [lobm_pkg::QTY_W-1:0]         trade_quantity;
    logic [lobm_pkg::REF_W-1:0]         taker_reference;

    book_scoreboard sb;
    int unsigned    cycles = 0;
    logic [lobm_pkg::REF_W-1:0] next_ref;

    limit_order_book_matcher_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .order_valid     (order_valid),
        .order_side      (order_side),
        .order_price     (order_price),
        .order_quantity  (order_quantity),
        .order_reference (order_reference),
        .result_valid    (result_valid),
        .matched         (matched),
        .trade_price     (trade_price),
        .trade_quantity  (trade_quantity),
        .taker_reference (taker_reference)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid)
            sb.check_fill({matched, trade_price, trade_quantity, taker_reference});

    // one beat, held until the block takes it; start stays high for the next beat
    task automatic send_order(logic vld, logic side, logic [lobm_pkg::PRICE_W-1:0] price,
                              logic [lobm_pkg::QTY_W-1:0] qty);
        start           <= 1'b1;
        order_valid     <= vld;
        order_side      <= side;
        order_price     <= price;
        order_quantity  <= qty;
        order_reference <= next_ref;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_order(vld, side, price, qty, next_ref);
        next_ref = $urandom();
    endtask

    task automatic idle(int unsigned n);
        start <= 1'b0;
        repeat (n)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [lobm_pkg::PRICE_W-1:0] rand_price();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return $urandom_range(LEVELS, 32'hFFFF_FFFF);
        if (r < 8)
            return $urandom_range(LEVELS - 4, LEVELS - 1);
        if (r < 13)
            return $urandom_range(0, 3);
        return $urandom_range(480, 543);
    endfunction

    function automatic logic [lobm_pkg::QTY_W-1:0] rand_qty();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 12)
            return $urandom();
        if (r < 16)
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        return $urandom_range(1, 200);
    endfunction

    initial
    begin
        int unsigned burst;
        sb = new();
        sb.clear();
        next_ref = 32'hA5A5_0001;
        rst_n = 1'b0;
        start = 1'b0;
        order_valid = 1'b0;
        order_side = 1'b0;
        order_price = '0;
        order_quantity = '0;
        order_reference = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: out-of-range prices, an invalid beat, empty book, level zero, top level, crossings, saturation
        send_order(1'b1, 1'b0, 32'hFFFF_FFFF, 32'd5);
        send_order(1'b1, 1'b1, LEVELS, 32'd5);
        send_order(1'b0, 1'b1, 32'd10, 32'd7);
        send_order(1'b1, 1'b0, 32'd0, 32'd9);
        send_order(1'b1, 1'b1, 32'd0, 32'd3);
        send_order(1'b1, 1'b0, 32'd100, 32'hFFFF_FFFF);
        send_order(1'b1, 1'b0, 32'd100, 32'd10);
        send_order(1'b1, 1'b1, 32'd100, 32'd0);
        send_order(1'b1, 1'b1, 32'd50, 32'hFFFF_FFFF);
        send_order(1'b1, 1'b1, 32'd90, 32'd4);
        send_order(1'b1, 1'b1, LEVELS - 1, 32'd6);
        send_order(1'b1, 1'b0, LEVELS - 1, 32'd20);
        send_order(1'b1, 1'b0, LEVELS - 1, 32'd0);
        send_order(1'b1, 1'b1, 32'd1, 32'd0);
        send_order(1'b1, 1'b0, 32'd1, 32'd8);
        send_order(1'b1, 1'b1, 32'd0, 32'hFFFF_FFFF);
        send_order(1'b1, 1'b1, 32'd0, 32'hFFFF_FFFF);
        send_order(1'b1, 1'b0, 32'd0, 32'd2);
        send_order(1'b1, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555);
        send_order(1'b1, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA);

        // wait for the book to settle before the random part
        drain();
        idle(LEVELS + 20);

        for (int n = 0; n < 1350;)
        begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst && n < 1350; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_order(1'b0, 1'($urandom()), $urandom(), $urandom());
                else
                begin
                    send_order(1'b1, 1'($urandom()), rand_price(), rand_qty());
                    n++;
                end
            end
            if ($urandom_range(0, 3) != 0)
                idle($urandom_range(1, 12));
        end

        drain();
        idle(LEVELS + 20);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
